@@ design/assert_macros.svh @@
// Assertion helpers for the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define CCS_ASSERT_NOW(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication, checked outside reset.
`define CCS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ design/ccs_pkg.sv @@
package ccs_pkg;

    typedef enum logic [2:0] {
        PH_CODE     = 3'd0,
        PH_STR      = 3'd1,
        PH_STR_ESC  = 3'd2,
        PH_CHR      = 3'd3,
        PH_CHR_ESC  = 3'd4,
        PH_SLASH    = 3'd5,
        PH_COMMENT  = 3'd6,
        PH_STAR     = 3'd7
    } phase_t;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_END  = 1'b1;

    localparam logic [1:0] KIND_CHAR     = 2'd0;
    localparam logic [1:0] KIND_END_OK   = 2'd1;
    localparam logic [1:0] KIND_END_OPEN = 2'd2;

    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam logic [31:0] LINE_FIRST = 32'd1;
    localparam logic [31:0] LINE_MAX   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic       command;
        logic [7:0] source_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  out_byte;
        logic [31:0] error_line;
        logic        last_of_run;
    } out_item_t;

    // Results of one accepted item, handed to the result queue.
    typedef struct packed {
        logic [1:0] count;
        out_item_t  item0;
        out_item_t  item1;
    } push_t;

    function automatic out_item_t mk_char(logic [7:0] c);
        out_item_t r;
        r.result_kind = KIND_CHAR;
        r.out_byte    = c;
        r.error_line  = '0;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    function automatic out_item_t mk_end(logic open, logic [31:0] line);
        out_item_t r;
        r.result_kind = open ? KIND_END_OPEN : KIND_END_OK;
        r.out_byte    = '0;
        r.error_line  = open ? line : '0;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    // Phase after a byte seen in plain code.
    function automatic phase_t code_phase(logic [7:0] c);
        phase_t p;
        if (c == CH_DQUOTE)
            p = PH_STR;
        else if (c == CH_SQUOTE)
            p = PH_CHR;
        else if (c == CH_SLASH)
            p = PH_SLASH;
        else
            p = PH_CODE;
        return p;
    endfunction

endpackage

@@ design/ccs_channels.sv @@
interface ccs_in_if
    import ccs_pkg::*;
();
    logic     valid;
    logic     ready;
    in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface ccs_out_if
    import ccs_pkg::*;
();
    logic      valid;
    logic      ready;
    out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ design/ccs_step.sv @@
module ccs_step
    import ccs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  in_item_t item_in,
    output push_t    push
);

    phase_t      phase_reg, phase_next;
    logic [31:0] line_reg, line_next;
    logic [31:0] start_reg, start_next;

    logic [7:0]  c;
    logic        open;
    out_item_t   report;
    out_item_t   item0, item1;
    logic [1:0]  cnt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_CODE;
            line_reg  <= LINE_FIRST;
            start_reg <= LINE_FIRST;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            line_reg  <= line_next;
            start_reg <= start_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        line_next  = line_reg;
        start_next = start_reg;
        c          = item_in.source_byte;
        open       = (phase_reg == PH_COMMENT) || (phase_reg == PH_STAR);
        report     = mk_end(open, start_reg);
        item0      = mk_char(CH_SPACE);
        item1      = mk_char(CH_SPACE);
        cnt        = 2'd0;

        if (item_in.command == CMD_END)
        begin
            // pending slash goes out ahead of the report
            if (phase_reg == PH_SLASH)
            begin
                item0 = mk_char(CH_SLASH);
                item1 = report;
                cnt   = 2'd2;
            end
            else
            begin
                item0 = report;
                cnt   = 2'd1;
            end
            phase_next = PH_CODE;
            line_next  = LINE_FIRST;
            start_next = LINE_FIRST;
        end
        else
        begin
            if (c == CH_NL && line_reg != LINE_MAX)
                line_next = line_reg + 32'd1;

            unique case (phase_reg)
                PH_CODE:
                begin
                    phase_next = code_phase(c);
                    if (c != CH_SLASH)
                    begin
                        item0 = mk_char(c);
                        cnt   = 2'd1;
                    end
                end
                PH_STR:
                begin
                    if (c == CH_BSLASH)
                        phase_next = PH_STR_ESC;
                    else if (c == CH_DQUOTE)
                        phase_next = PH_CODE;
                    item0 = mk_char(c);
                    cnt   = 2'd1;
                end
                PH_STR_ESC:
                begin
                    phase_next = PH_STR;
                    item0      = mk_char(c);
                    cnt        = 2'd1;
                end
                PH_CHR:
                begin
                    if (c == CH_BSLASH)
                        phase_next = PH_CHR_ESC;
                    else if (c == CH_SQUOTE)
                        phase_next = PH_CODE;
                    item0 = mk_char(c);
                    cnt   = 2'd1;
                end
                PH_CHR_ESC:
                begin
                    phase_next = PH_CHR;
                    item0      = mk_char(c);
                    cnt        = 2'd1;
                end
                PH_SLASH:
                begin
                    if (c == CH_STAR)
                    begin
                        phase_next = PH_COMMENT;
                        start_next = line_next;
                    end
                    else if (c == CH_SLASH)
                    begin
                        // first slash out, second stays pending
                        item0 = mk_char(CH_SLASH);
                        cnt   = 2'd1;
                    end
                    else
                    begin
                        item0      = mk_char(CH_SLASH);
                        item1      = mk_char(c);
                        cnt        = 2'd2;
                        phase_next = code_phase(c);
                    end
                end
                PH_COMMENT:
                begin
                    if (c == CH_NL)
                    begin
                        item0 = mk_char(c);
                        cnt   = 2'd1;
                    end
                    else if (c == CH_STAR)
                        phase_next = PH_STAR;
                end
                PH_STAR:
                begin
                    if (c == CH_SLASH)
                    begin
                        phase_next = PH_CODE;
                        item0      = mk_char(CH_SPACE);
                        cnt        = 2'd1;
                    end
                    else if (c != CH_STAR)
                    begin
                        phase_next = PH_COMMENT;
                        if (c == CH_NL)
                        begin
                            item0 = mk_char(c);
                            cnt   = 2'd1;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_CODE;
                end
            endcase
        end

        item0.last_of_run = (cnt == 2'd1);
        item1.last_of_run = 1'b1;
    end

    assign push.count = accept ? cnt : 2'd0;
    assign push.item0 = item0;
    assign push.item1 = item1;

endmodule

@@ design/ccs_result_fifo.sv @@
module ccs_result_fifo
    import ccs_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  push_t            push,
    output logic             room,
    ccs_out_if.source        results
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    out_item_t               mem [DEPTH];
    logic [PTR_W-1:0]        wr_reg, wr_next, rd_reg, rd_next, wr_second;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    pop;

    function automatic logic [PTR_W-1:0] inc(logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign pop       = results.valid && results.ready;
    assign wr_second = inc(wr_reg);

    always_comb
    begin
        case (push.count)
            2'd1:    wr_next = wr_second;
            2'd2:    wr_next = inc(wr_second);
            default: wr_next = wr_reg;
        endcase
        rd_next  = pop ? inc(rd_reg) : rd_reg;
        cnt_next = cnt_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[wr_reg] <= push.item0;
        if (push.count == 2'd2)
            mem[wr_second] <= push.item1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // space for the two results an item may cause
    assign room            = (cnt_reg <= CNT_W'(DEPTH - 2));
    assign results.valid   = (cnt_reg != '0);
    assign results.payload = mem[rd_reg];

endmodule

@@ design/c_comment_stripper.sv @@
// C block comment stripper.
// chars (sink side): one transfer per source byte (command = 0) or per
//   end-of-input marker (command = 1). A transfer completes when valid and
//   ready are both high at a rising edge of clk.
// results (source side): one transfer per result item: a kept character, or
//   an end report (end ok, or unterminated comment with its start line).
//   last_of_run marks the final result caused by one input transfer.
// Ordering: results are written to the queue when their input transfers and are offered from it in order.
// Throughput: one input per cycle while each yields at most one result and
//   the receiver keeps ready high; a byte that yields two results (a pending
//   slash plus the byte) needs two result transfers, so the rate is then set
//   by the one-per-cycle drain of the result queue.
// Stall: results wait in a small queue; chars.ready drops only when the queue
//   lacks room for two results, so the input keeps flowing during a short
//   receiver stall.
// Reset (rst_n, async, active low): machine in plain code, line counter and
//   comment start line at 1, queue empty. An end-of-input marker returns the
//   machine to that same state.
`include "assert_macros.svh"

module c_comment_stripper
    import ccs_pkg::*;
#(
    parameter int RESULT_DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    ccs_in_if.sink    chars,
    ccs_out_if.source results
);

    logic  accept;
    logic  room;
    push_t push;

    assign chars.ready = room;
    assign accept      = chars.valid && room;

    // phase machine and line tracking
    ccs_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .item_in (chars.payload),
        .push    (push)
    );

    // result queue, drains one result per cycle while the receiver is ready
    ccs_result_fifo #(
        .DEPTH (RESULT_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .room    (room),
        .results (results)
    );

    // An end marker always produces its report.
    `CCS_ASSERT_IMPL(a_end_reports, clk, rst_n, accept && chars.payload.command == CMD_END, push.count != 2'd0, "end marker produced no report")

    // Only the second of a pair closes the run.
    `CCS_ASSERT_IMPL(a_pair_last, clk, rst_n, push.count == 2'd2, push.item1.last_of_run && !push.item0.last_of_run, "bad last_of_run on result pair")

    // End reports always close their run; characters carry no line.
    `CCS_ASSERT_IMPL(a_report_last, clk, rst_n, results.valid && results.payload.result_kind != KIND_CHAR, results.payload.last_of_run, "end report not last of run")
    `CCS_ASSERT_IMPL(a_char_line, clk, rst_n, results.valid && results.payload.result_kind == KIND_CHAR, results.payload.error_line == 32'd0, "character with a line number")

endmodule

@@ sim/c_comment_stripper_tb.sv @@
// Stand-alone bench for the C block comment stripper.
// Source text goes in one byte per transfer, plus end-of-input markers.
// Every accepted input runs through a local model of the lexer. The results
// that input should cause are queued, and each result transfer is checked
// against the head of that queue.

module c_comment_stripper_tb;
    import ccs_pkg::*;

    // Generous ceiling. The slowest legal run is roughly 450 inputs, each
    // with the largest sender gap plus two results that each wait out the
    // largest receiver gap, plus the long hold. That is well under this limit.
    localparam int CYCLE_LIMIT  = 400000;
    // Settle time after the last expected result, to catch stray results.
    localparam int DRAIN_CYCLES = 16;
    // Length of the receiver hold in the back-pressure test.
    localparam int HOLD_CYCLES  = 120;

    logic clk;
    logic rst_n;

    ccs_in_if  chars();
    ccs_out_if results();

    c_comment_stripper uut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars),
        .results (results)
    );

    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Local copy of the lexer state.
    phase_t      lex_phase;
    logic [31:0] line_no;
    logic [31:0] cmt_line;

    // Results still to come from the block, oldest first.
    out_item_t stripped_q[$];
    // Results of the input currently being modeled.
    out_item_t run_buf[$];

    int cycle_count = 0;
    int mismatches  = 0;
    int items_sent  = 0;

    // Upper bounds of the per-transfer idle draws. They are changed per phase
    // so that some stretches run back to back and others are heavily gapped.
    int in_gap_max  = 3;
    int out_gap_max = 3;
    // While this is set, the receiver keeps ready low.
    logic hold_results;

    // ------------------------------------------------------------------
    // Lexer model
    // ------------------------------------------------------------------

    function automatic void keep_char(logic [7:0] c);
        out_item_t r;
        r = '0;
        r.result_kind = KIND_CHAR;
        r.out_byte    = c;
        run_buf.push_back(r);
    endfunction

    // A byte seen in plain code. A slash is held back until the next byte
    // shows whether it opens a comment.
    function automatic void code_char(logic [7:0] c);
        if (c == CH_SLASH)
        begin
            lex_phase = PH_SLASH;
            return;
        end
        if (c == CH_DQUOTE)
            lex_phase = PH_STR;
        else if (c == CH_SQUOTE)
            lex_phase = PH_CHR;
        else
            lex_phase = PH_CODE;
        keep_char(c);
    endfunction

    function automatic void lexer_reset();
        lex_phase = PH_CODE;
        line_no   = LINE_FIRST;
        cmt_line  = LINE_FIRST;
    endfunction

    // Model one accepted input and queue the results it causes.
    function automatic void strip_byte(logic cmd, logic [7:0] c);
        out_item_t r;
        logic      cmt_open;
        run_buf.delete();
        if (cmd == CMD_END)
        begin
            cmt_open = (lex_phase == PH_COMMENT) || (lex_phase == PH_STAR);
            // a pending slash is flushed before the report
            if (lex_phase == PH_SLASH)
                keep_char(CH_SLASH);
            r = '0;
            r.result_kind = cmt_open ? KIND_END_OPEN : KIND_END_OK;
            r.error_line  = cmt_open ? cmt_line : '0;
            run_buf.push_back(r);
            lexer_reset();
        end
        else
        begin
            // newlines are counted before the byte is handled; saturating
            if (c == CH_NL && line_no != LINE_MAX)
                line_no = line_no + 1;
            case (lex_phase)
                PH_CODE:
                    code_char(c);
                PH_STR:
                begin
                    if (c == CH_BSLASH)
                        lex_phase = PH_STR_ESC;
                    else if (c == CH_DQUOTE)
                        lex_phase = PH_CODE;
                    keep_char(c);
                end
                PH_STR_ESC:
                begin
                    lex_phase = PH_STR;
                    keep_char(c);
                end
                PH_CHR:
                begin
                    if (c == CH_BSLASH)
                        lex_phase = PH_CHR_ESC;
                    else if (c == CH_SQUOTE)
                        lex_phase = PH_CODE;
                    keep_char(c);
                end
                PH_CHR_ESC:
                begin
                    lex_phase = PH_CHR;
                    keep_char(c);
                end
                PH_SLASH:
                begin
                    if (c == CH_STAR)
                    begin
                        lex_phase = PH_COMMENT;
                        cmt_line  = line_no;
                    end
                    else if (c == CH_SLASH)
                        keep_char(CH_SLASH);    // second slash stays pending
                    else
                    begin
                        keep_char(CH_SLASH);
                        code_char(c);
                    end
                end
                PH_COMMENT:
                begin
                    if (c == CH_NL)
                        keep_char(c);
                    else if (c == CH_STAR)
                        lex_phase = PH_STAR;
                end
                PH_STAR:
                begin
                    if (c == CH_SLASH)
                    begin
                        lex_phase = PH_CODE;
                        keep_char(CH_SPACE);    // closing the comment yields one space; body newlines were kept
                    end
                    else if (c != CH_STAR)
                    begin
                        lex_phase = PH_COMMENT;
                        if (c == CH_NL)
                            keep_char(c);
                    end
                end
            endcase
        end
        if (run_buf.size() > 0)
            run_buf[run_buf.size() - 1].last_of_run = 1'b1;
        foreach (run_buf[i])
            stripped_q.push_back(run_buf[i]);
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one item and return at the edge where the transfer happens.
    // valid is only lowered when a gap is drawn, so back-to-back items keep
    // it high with a single assignment per edge.
    task automatic send_item(input logic cmd, input logic [7:0] c);
        in_item_t it;
        int       gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0)
        begin
            chars.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        it.command     = cmd;
        it.source_byte = c;
        chars.valid   <= 1'b1;
        chars.payload <= it;
        do
            @(posedge clk);
        while (chars.ready !== 1'b1);
        strip_byte(cmd, c);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(CMD_BYTE, s[i]);
    endtask

    // Byte biased toward the characters the lexer cares about.
    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 11))
            0: return CH_DQUOTE;
            1: return CH_SQUOTE;
            2: return CH_SLASH;
            3: return CH_STAR;
            4: return CH_BSLASH;
            5: return CH_NL;
            6: return CH_SPACE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    // Receiver: draw a wait before each result, then hold ready high until
    // a transfer. The back-pressure test can also freeze it.
    initial
    begin : result_sink
        int w;
        results.ready = 1'b0;
        forever
        begin
            w = $urandom_range(0, out_gap_max);
            if (w > 0 || hold_results)
            begin
                results.ready <= 1'b0;
                repeat (w) @(posedge clk);
                while (hold_results)
                    @(posedge clk);
            end
            results.ready <= 1'b1;
            do
                @(posedge clk);
            while (results.valid !== 1'b1);
        end
    end

    task automatic flag(input string msg);
        $display("MISMATCH cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : result_check
        out_item_t got;
        out_item_t want;
        if (rst_n && results.valid === 1'b1 && results.ready === 1'b1)
        begin
            got = results.payload;
            if (stripped_q.size() == 0)
                flag($sformatf("result with nothing pending: kind %0d byte %02h line %0d",
                               got.result_kind, got.out_byte, got.error_line));
            else
            begin
                want = stripped_q.pop_front();
                if (got.result_kind !== want.result_kind)
                    flag($sformatf("result_kind %0d, want %0d",
                                   got.result_kind, want.result_kind));
                if (got.out_byte !== want.out_byte)
                    flag($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
                if (got.error_line !== want.error_line)
                    flag($sformatf("error_line %0d, want %0d",
                                   got.error_line, want.error_line));
                if (got.last_of_run !== want.last_of_run)
                    flag($sformatf("last_of_run %0b, want %0b",
                                   got.last_of_run, want.last_of_run));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // String with an escaped quote and a fake comment opener inside it,
    // then a character literal holding an escaped quote.
    task automatic test_quoted_text();
        send_text("\"\\\"/*\"");
        send_text("'\\''");
    endtask

    // Comment handling: slash-slash leaves the second slash pending, a
    // slash before a quote opens a literal (closed by the end marker,
    // which must report end ok), then a comment spanning lines with a
    // double star and a newline right after a star.
    task automatic test_comments();
        send_text("//'");
        send_item(CMD_END, 8'hFF);
        send_text("/*\n**\n*/");
    endtask

    // End marker cases: unterminated comment opened on line 2, and a
    // pending slash flushed ahead of the end report.
    task automatic test_end_marker();
        send_text("\n/*");
        send_item(CMD_END, 8'h00);
        send_item(CMD_BYTE, CH_SLASH);
        send_item(CMD_END, 8'h5A);
    endtask

    // Receiver stops for a long stretch while the sender keeps offering
    // slash/letter pairs (two results per pair), so the result buffer fills
    // up and the block has to drop ready on its input.
    task automatic test_backpressure();
        in_gap_max   = 0;
        out_gap_max  = 0;
        hold_results <= 1'b1;
        fork
            begin
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_results <= 1'b0;
            end
            begin
                for (int i = 0; i < 24; i++)
                    send_item(CMD_BYTE, (i % 2 == 0) ? CH_SLASH : 8'h61);
            end
        join
    endtask

    // Mostly well-formed C fragments with random content; the rest is raw
    // noise, unclosed quotes and comments, and end markers.
    task automatic random_text(input int n_items);
        int first;
        int pick;
        int len;
        first = items_sent;
        while (items_sent - first < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                len = $urandom_range(1, 6);
                repeat (len) send_item(CMD_BYTE, pick_char());
            end
            else if (pick < 48)
            begin
                // string literal, may close early on a random quote
                send_item(CMD_BYTE, CH_DQUOTE);
                len = $urandom_range(0, 8);
                repeat (len)
                begin
                    if ($urandom_range(0, 4) == 0)
                        send_item(CMD_BYTE, CH_BSLASH);
                    send_item(CMD_BYTE, pick_char());
                end
                if ($urandom_range(0, 9) != 0)
                    send_item(CMD_BYTE, CH_DQUOTE);
            end
            else if (pick < 58)
            begin
                send_item(CMD_BYTE, CH_SQUOTE);
                if ($urandom_range(0, 2) == 0)
                    send_item(CMD_BYTE, CH_BSLASH);
                send_item(CMD_BYTE, pick_char());
                if ($urandom_range(0, 9) != 0)
                    send_item(CMD_BYTE, CH_SQUOTE);
            end
            else if (pick < 80)
            begin
                // block comment with stars and newlines in the body
                send_item(CMD_BYTE, CH_SLASH);
                send_item(CMD_BYTE, CH_STAR);
                len = $urandom_range(0, 10);
                repeat (len) send_item(CMD_BYTE, pick_char());
                if ($urandom_range(0, 6) != 0)
                begin
                    send_item(CMD_BYTE, CH_STAR);
                    send_item(CMD_BYTE, CH_SLASH);
                end
            end
            else if (pick < 92)
            begin
                len = $urandom_range(1, 4);
                repeat (len) send_item(CMD_BYTE, 8'($urandom_range(0, 255)));
            end
            else
                send_item(CMD_END, 8'($urandom_range(0, 255)));
        end
    endtask

    // Random text under four pacing mixes: no idling, both sides gapped,
    // slow receiver, slow sender.
    task automatic test_random_text();
        in_gap_max  = 0;
        out_gap_max = 0;
        random_text(90);
        in_gap_max  = 18;
        out_gap_max = 18;
        random_text(90);
        in_gap_max  = 0;
        out_gap_max = 18;
        random_text(95);
        in_gap_max  = 18;
        out_gap_max = 0;
        random_text(95);
        send_item(CMD_END, 8'h00);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin : main
        chars.valid   = 1'b0;
        chars.payload = '0;
        hold_results  = 1'b0;
        rst_n         = 1'b0;
        lexer_reset();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_quoted_text();
        test_comments();
        test_end_marker();
        test_backpressure();
        test_random_text();

        chars.valid <= 1'b0;
        while (stripped_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/ccs_pkg.sv
design/ccs_channels.sv
design/ccs_step.sv
design/ccs_result_fifo.sv
design/c_comment_stripper.sv
sim/c_comment_stripper_tb.sv
